// ===== rtl/core/mrukc_pkg.sv =====
package mrukc_pkg;

  // Configuration register width and reset value
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = 5'd16;

  // Request codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;  // latch request and register the compare vector
    logic update;   // reorder the stack and load the result register
  } mrukc_cmd_t;

endpackage

// ===== rtl/core/mrukc_if.sv =====
// Request channel
interface mrukc_in_if #(
  parameter int KEY_WIDTH = 32
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [KEY_WIDTH-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

// Result channel
interface mrukc_out_if #(
  parameter int KEY_WIDTH = 32
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 evicted_valid;
  logic [KEY_WIDTH-1:0] evicted_key;

  modport source (output valid, output hit, output evicted_valid, output evicted_key,
                  input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_key,
                  output ready);
endinterface

// ===== rtl/core/mrukc_ctrl.sv =====
module mrukc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mrukc_pkg::mrukc_cmd_t cmd
);
  import mrukc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer: accept, then update once the result register can take the result
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.capture   = 1'b0;
    cmd.update    = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/mrukc_dpath.sv =====
module mrukc_dpath #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mrukc_pkg::mrukc_cmd_t      cmd,
  input  logic                       cfg_wr_en,
  input  logic [mrukc_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_req_type,
  input  logic [KEY_WIDTH-1:0]       in_key,
  output logic                       out_hit,
  output logic                       out_evicted_valid,
  output logic [KEY_WIDTH-1:0]       out_evicted_key
);
  import mrukc_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [KEY_WIDTH-1:0] stack_r [CAPACITY];
  logic [KEY_WIDTH-1:0] stack_nxt [CAPACITY];
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CFG_W-1:0]     limit_r;
  logic [CAPACITY-1:0]  match_r, match_nxt;
  logic [CAPACITY-1:0]  shift_mask;
  logic                 req_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 hit_r, ev_valid_r;
  logic [KEY_WIDTH-1:0] ev_key_r;
  logic                 hit, evict;
  logic [LIM_W-1:0]     lim_ext, lim_eff, cnt_ext;

  // Parallel compare of the incoming key against the occupied entries
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (stack_r[i] == in_key) && (CNT_W'(i) < count_r);
    end
  end

  // Entries at or in front of the hit position move back by one
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      shift_mask[i] = |(match_r >> i);
    end
  end

  // Effective limit, clamped to 1..CAPACITY
  always_comb begin
    lim_ext = LIM_W'(limit_r);
    cnt_ext = LIM_W'(count_r);
    if (lim_ext == '0) begin
      lim_eff = LIM_W'(1);
    end else if (lim_ext > LIM_W'(CAPACITY)) begin
      lim_eff = LIM_W'(CAPACITY);
    end else begin
      lim_eff = lim_ext;
    end
  end

  assign hit   = |match_r;
  assign evict = !hit && (req_r == REQ_ADD) && (cnt_ext >= lim_eff);

  // Next stack contents and fill count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      stack_nxt[i] = stack_r[i];
    end
    count_nxt = count_r;
    if (hit) begin
      for (int i = 1; i < CAPACITY; i++) begin
        if (shift_mask[i]) begin
          stack_nxt[i] = stack_r[i-1];
        end
      end
      stack_nxt[0] = key_r;
    end else if (req_r == REQ_ADD) begin
      if (evict) begin
        stack_nxt[0] = key_r;
      end else begin
        for (int i = 1; i < CAPACITY; i++) begin
          stack_nxt[i] = stack_r[i-1];
        end
        stack_nxt[0] = key_r;
        count_nxt    = count_r + CNT_W'(1);
      end
    end
  end

  // Key stack and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      key_r   <= in_key;
      match_r <= match_nxt;
    end
    if (cmd.update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        stack_r[i] <= stack_nxt[i];
      end
      hit_r      <= hit;
      ev_valid_r <= evict;
      ev_key_r   <= evict ? stack_r[0] : '0;
    end
  end

  // Fill count and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= CFG_LIMIT_RESET;
    end else begin
      if (cmd.update) begin
        count_r <= count_nxt;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  assign out_hit           = hit_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_key   = ev_key_r;

endmodule

// ===== rtl/core/mru_replacement_key_cache_top.sv =====
// Most-recently-used replacement key cache.
// in_ch carries one request per transaction: req_type (add or find) and key.
// out_ch returns exactly one result per request: hit, evicted_valid and
// evicted_key (zero when nothing was evicted), in request order.
// cfg_wr_en/cfg_wr_data write the 5-bit capacity limit; write it only while
// no request is in flight.
// Timing: a request is accepted in the idle state, its key compared against
// all stored keys at that edge; the update step then reorders the recency
// stack and loads the result register once the result register is free.
// A new request is accepted only after the previous one has completed its
// update step.
// If the receiver stalls, the finished result waits in the result register;
// one further request may be accepted and is held at its update step until
// the waiting result is taken.
// Reset empties the store (fill count zero), sets the limit to 16, drops
// the result valid and idles the sequencer; stored keys need no clearing.
module mru_replacement_key_cache_top #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mrukc_in_if.sink                    in_ch,
  mrukc_out_if.source                 out_ch,
  input  logic                        cfg_wr_en,
  input  logic [mrukc_pkg::CFG_W-1:0] cfg_wr_data
);
  import mrukc_pkg::*;

  mrukc_cmd_t cmd;

  // Sequencer
  mrukc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Key stack, compare and result register
  mrukc_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_ch.req_type),
    .in_key            (in_ch.key),
    .out_hit           (out_ch.hit),
    .out_evicted_valid (out_ch.evicted_valid),
    .out_evicted_key   (out_ch.evicted_key)
  );

  // One request in flight: no acceptance in the cycle after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted during update cycle");

  // An eviction only happens on a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.evicted_valid) |-> !out_ch.hit)
    else $error("eviction reported together with a hit");

  // Evicted key is zero when nothing was evicted
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.evicted_valid) |-> (out_ch.evicted_key == '0))
    else $error("non-zero evicted key without eviction");

endmodule
